@@ rtl/core/smac_pkg.sv @@
package smac_pkg;

    // Shadow store geometry
    localparam int SHADOW_ENTRIES = 4096;
    localparam int GRANULE_SHIFT  = 3;
    localparam int IDX_W          = $clog2(SHADOW_ENTRIES);
    localparam int OFF_W          = IDX_W + GRANULE_SHIFT;

    // Field widths
    localparam int ADDR_W  = 48;
    localparam int COUNT_W = 16;
    localparam int SHADOW_W = 8;

    // Item modes
    localparam logic [1:0] MODE_CHECK_READ  = 2'd0;
    localparam logic [1:0] MODE_CHECK_WRITE = 2'd1;
    localparam logic [1:0] MODE_POISON      = 2'd2;
    localparam logic [1:0] MODE_UNPOISON    = 2'd3;

    // Configuration register indexes
    localparam logic CFG_CHECKER_ENABLE = 1'b0;
    localparam logic CFG_WINDOW_BASE    = 1'b1;

    typedef logic [IDX_W-1:0] gran_idx_t;

    // Request from the front end to the granule walker
    typedef struct packed {
        logic                     launch;
        logic                     is_check;
        gran_idx_t                first;
        gran_idx_t                last;
        logic [GRANULE_SHIFT-1:0] end_off;
        logic [SHADOW_W-1:0]      wval;
    } walk_req_t;

    // Status from the granule walker
    typedef struct packed {
        logic idle;
        logic finish;
        logic hit;
    } walk_stat_t;

endpackage

@@ rtl/core/shadow_memory_access_checker_core.sv @@
// Channel   Handshake          Payload
// request   start / busy       mode, address, byte_count, shadow_value
// result    done (one cycle)   violation, ignored, fault_address, fault_size,
//                              fault_is_write
// config    cfg_write          cfg_index, cfg_data
//
// After reset a clearing pass zeroes the shadow store, one entry a cycle:
// busy stays high until all SHADOW_ENTRIES (4096) entries are cleared.
// A request is taken when start is high and busy is low; done then pulses once
// with its result, after the granules of the range have been walked (a check
// ends early on a hit; an ignored or empty request walks none).
// The walker goes over the single port of the shadow store one granule a cycle.
// The receiver cannot stall: each result shows for exactly one cycle.
module shadow_memory_access_checker_core
    import smac_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          mode,
    input  logic [ADDR_W-1:0]   address,
    input  logic [COUNT_W-1:0]  byte_count,
    input  logic [SHADOW_W-1:0] shadow_value,
    output logic                done,
    output logic                violation,
    output logic                ignored,
    output logic [ADDR_W-1:0]   fault_address,
    output logic [COUNT_W-1:0]  fault_size,
    output logic                fault_is_write,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [ADDR_W-1:0]   cfg_data
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_OFFSET = 2'd1;
    localparam logic [1:0] S_RANGE  = 2'd2;
    localparam logic [1:0] S_WAIT   = 2'd3;

    localparam int END_W = ((OFF_W > COUNT_W) ? OFF_W : COUNT_W) + 1;
    localparam int LG_W  = END_W - GRANULE_SHIFT;
    localparam logic [ADDR_W-1:0] SPAN = ADDR_W'(SHADOW_ENTRIES) << GRANULE_SHIFT;
    localparam logic [LG_W-1:0]   ENTRIES_LG = LG_W'(SHADOW_ENTRIES);
    localparam gran_idx_t         IDX_LAST = IDX_W'(SHADOW_ENTRIES - 1);

    logic [1:0]          state_reg, state_next;
    logic                enable_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic [1:0]          mode_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [SHADOW_W-1:0] value_reg;
    logic [OFF_W-1:0]    off_reg, off_next;

    logic                done_reg, done_next;
    logic                violation_reg, violation_next;
    logic                ignored_reg, ignored_next;
    logic [ADDR_W-1:0]   fault_address_reg, fault_address_next;
    logic [COUNT_W-1:0]  fault_size_reg, fault_size_next;
    logic                fault_is_write_reg, fault_is_write_next;

    logic                accept;
    logic [ADDR_W:0]     diff;
    logic [ADDR_W-1:0]   base_aligned;
    logic                out_window;
    logic [END_W-1:0]    end_pos;
    logic [LG_W-1:0]     last_lg;
    logic                clipped;
    logic                is_check;
    walk_req_t           req;
    walk_stat_t          stat;

    assign accept       = start && !busy;
    assign busy         = (state_reg != S_IDLE) || !stat.idle;
    assign is_check     = (mode_reg == MODE_CHECK_READ) || (mode_reg == MODE_CHECK_WRITE);

    // Offset into the window, borrow marks an address below the base
    assign base_aligned = {base_reg[ADDR_W-1:GRANULE_SHIFT], {GRANULE_SHIFT{1'b0}}};
    assign diff         = {1'b0, addr_reg} - {1'b0, base_aligned};
    assign out_window   = !enable_reg || (addr_reg == '0) || diff[ADDR_W]
                          || (diff[ADDR_W-1:0] >= SPAN);

    // Last granule of the range, clipped at the window end
    assign end_pos = END_W'(off_reg) + END_W'(count_reg) - END_W'(1);
    assign last_lg = end_pos[END_W-1:GRANULE_SHIFT];
    assign clipped = (last_lg >= ENTRIES_LG);

    always_comb
    begin
        req.launch   = (state_reg == S_RANGE) && (count_reg != '0);
        req.is_check = is_check;
        req.first    = off_reg[OFF_W-1:GRANULE_SHIFT];
        req.last     = clipped ? IDX_LAST : last_lg[IDX_W-1:0];
        req.end_off  = clipped ? '1 : end_pos[GRANULE_SHIFT-1:0];
        req.wval     = (mode_reg == MODE_POISON) ? value_reg : '0;
    end

    smac_granule_walker u_walker (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .stat  (stat)
    );

    // Front-end sequencer and result formation
    always_comb
    begin
        state_next          = state_reg;
        off_next            = off_reg;
        done_next           = 1'b0;
        violation_next      = violation_reg;
        ignored_next        = ignored_reg;
        fault_address_next  = fault_address_reg;
        fault_size_next     = fault_size_reg;
        fault_is_write_next = fault_is_write_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_OFFSET;
                end
            end
            S_OFFSET:
            begin
                off_next = diff[OFF_W-1:0];
                if (out_window)
                begin
                    done_next           = 1'b1;
                    violation_next      = 1'b0;
                    ignored_next        = 1'b1;
                    fault_address_next  = '0;
                    fault_size_next     = '0;
                    fault_is_write_next = 1'b0;
                    state_next          = S_IDLE;
                end
                else
                begin
                    state_next = S_RANGE;
                end
            end
            S_RANGE:
            begin
                if (count_reg == '0)
                begin
                    done_next           = 1'b1;
                    violation_next      = 1'b0;
                    ignored_next        = 1'b0;
                    fault_address_next  = '0;
                    fault_size_next     = '0;
                    fault_is_write_next = 1'b0;
                    state_next          = S_IDLE;
                end
                else
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (stat.finish)
                begin
                    done_next           = 1'b1;
                    ignored_next        = 1'b0;
                    violation_next      = stat.hit && is_check;
                    fault_address_next  = (stat.hit && is_check) ? addr_reg : '0;
                    fault_size_next     = (stat.hit && is_check) ? count_reg : '0;
                    fault_is_write_next = stat.hit && (mode_reg == MODE_CHECK_WRITE);
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            enable_reg <= 1'b0;
            base_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_CHECKER_ENABLE: enable_reg <= cfg_data[0];
                    CFG_WINDOW_BASE:    base_reg   <= cfg_data;
                    default:            enable_reg <= enable_reg;
                endcase
            end
        end
    end

    // Capture the request and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= mode;
            addr_reg  <= address;
            count_reg <= byte_count;
            value_reg <= shadow_value;
        end
        off_reg            <= off_next;
        violation_reg      <= violation_next;
        ignored_reg        <= ignored_next;
        fault_address_reg  <= fault_address_next;
        fault_size_reg     <= fault_size_next;
        fault_is_write_reg <= fault_is_write_next;
    end

    assign done           = done_reg;
    assign violation      = violation_reg;
    assign ignored        = ignored_reg;
    assign fault_address  = fault_address_reg;
    assign fault_size     = fault_size_reg;
    assign fault_is_write = fault_is_write_reg;

endmodule

@@ rtl/core/smac_granule_walker.sv @@
module smac_granule_walker
    import smac_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  walk_req_t  req,
    output walk_stat_t stat
);

    localparam logic [2:0] W_CLEAR = 3'd0;
    localparam logic [2:0] W_IDLE  = 3'd1;
    localparam logic [2:0] W_WRITE = 3'd2;
    localparam logic [2:0] W_SCAN  = 3'd3;
    localparam logic [2:0] W_DRAIN = 3'd4;

    localparam gran_idx_t IDX_LAST = IDX_W'(SHADOW_ENTRIES - 1);

    logic [SHADOW_W-1:0] mem [SHADOW_ENTRIES];

    logic [2:0]               state_reg, state_next;
    gran_idx_t                idx_reg, idx_next;
    gran_idx_t                last_reg, last_next;
    logic [GRANULE_SHIFT-1:0] end_off_reg, end_off_next;
    logic [SHADOW_W-1:0]      wval_reg, wval_next;
    logic                     pend_reg, pend_next;
    logic                     pend_last_reg, pend_last_next;
    logic [SHADOW_W-1:0]      rd_data_reg;

    logic                     mem_we;
    logic [SHADOW_W-1:0]      mem_wdata;
    logic [GRANULE_SHIFT-1:0] hi_off;
    logic                     hit_now;

    // Judge the shadow byte read in the previous cycle
    assign hi_off  = pend_last_reg ? end_off_reg : '1;
    assign hit_now = pend_reg && (rd_data_reg != '0)
                     && (rd_data_reg[SHADOW_W-1]
                         || (SHADOW_W'(hi_off) >= rd_data_reg));

    // Sequence the clear pass, range writes and pipelined scans
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        end_off_next   = end_off_reg;
        wval_next      = wval_reg;
        pend_next      = 1'b0;
        pend_last_next = pend_last_reg;
        mem_we         = 1'b0;
        mem_wdata      = '0;
        stat.idle      = 1'b0;
        stat.finish    = 1'b0;
        stat.hit       = 1'b0;

        unique case (state_reg)
            W_CLEAR:
            begin
                mem_we = 1'b1;
                if (idx_reg == IDX_LAST)
                begin
                    state_next = W_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            W_IDLE:
            begin
                stat.idle = 1'b1;
                if (req.launch)
                begin
                    idx_next     = req.first;
                    last_next    = req.last;
                    end_off_next = req.end_off;
                    wval_next    = req.wval;
                    state_next   = req.is_check ? W_SCAN : W_WRITE;
                end
            end
            W_WRITE:
            begin
                mem_we    = 1'b1;
                mem_wdata = wval_reg;
                if (idx_reg == last_reg)
                begin
                    stat.finish = 1'b1;
                    state_next  = W_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            W_SCAN:
            begin
                if (hit_now)
                begin
                    stat.finish = 1'b1;
                    stat.hit    = 1'b1;
                    state_next  = W_IDLE;
                end
                else
                begin
                    pend_next      = 1'b1;
                    pend_last_next = (idx_reg == last_reg);
                    if (idx_reg == last_reg)
                    begin
                        state_next = W_DRAIN;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            W_DRAIN:
            begin
                stat.finish = 1'b1;
                stat.hit    = hit_now;
                state_next  = W_IDLE;
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= W_CLEAR;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg    <= last_next;
        end_off_reg <= end_off_next;
        wval_reg    <= wval_next;
    end

    // Shadow store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= mem_wdata;
        end
        rd_data_reg <= mem[idx_reg];
    end

endmodule

@@ rtl/core/smac_checker.sv @@
module smac_checker
    import smac_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic                violation,
    input logic                ignored,
    input logic [ADDR_W-1:0]   fault_address,
    input logic [COUNT_W-1:0]  fault_size,
    input logic                fault_is_write
);

    // An accepted request keeps the block busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but block not busy");

    // Results never come back to back
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");

    // An ignored request never reports a violation
    a_ignored_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && ignored |-> !violation)
        else $error("violation on ignored request");

    // Fault fields stay zero without a violation
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !violation |-> (fault_address == '0) && (fault_size == '0)
                               && !fault_is_write)
        else $error("fault fields set without violation");

    // A violation comes only from a nonzero length
    a_fault_size: assert property (@(posedge clk) disable iff (!rst_n)
        done && violation |-> (fault_size != '0))
        else $error("violation with zero length");

endmodule

bind shadow_memory_access_checker_core smac_checker u_smac_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .violation      (violation),
    .ignored        (ignored),
    .fault_address  (fault_address),
    .fault_size     (fault_size),
    .fault_is_write (fault_is_write)
);

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import smac_pkg::*;

    localparam int                WINDOW_SPAN = SHADOW_ENTRIES << GRANULE_SHIFT;
    localparam logic [ADDR_W-1:0] GRAN_LOW    = ADDR_W'((1 << GRANULE_SHIFT) - 1);

    typedef struct packed {
        logic               violation;
        logic               ignored;
        logic [ADDR_W-1:0]  fault_address;
        logic [COUNT_W-1:0] fault_size;
        logic               fault_is_write;
    } outcome_t;

    typedef struct {
        logic [1:0]          md;
        logic [ADDR_W-1:0]   addr;
        logic [COUNT_W-1:0]  cnt;
        logic [SHADOW_W-1:0] val;
        bit                  typed;
        outcome_t            want;
    } step_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [1:0]          mode = MODE_CHECK_READ;
    logic [ADDR_W-1:0]   address = '0;
    logic [COUNT_W-1:0]  byte_count = '0;
    logic [SHADOW_W-1:0] shadow_value = '0;
    logic                done;
    logic                violation;
    logic                ignored;
    logic [ADDR_W-1:0]   fault_address;
    logic [COUNT_W-1:0]  fault_size;
    logic                fault_is_write;
    logic                cfg_write = 1'b0;
    logic                cfg_index = CFG_CHECKER_ENABLE;
    logic [ADDR_W-1:0]   cfg_data = '0;

    // Mirror of the block: shadow bytes and both registers
    logic [SHADOW_W-1:0] shadow_ref [SHADOW_ENTRIES];
    logic                chk_en = 1'b0;
    logic [ADDR_W-1:0]   win_base = '0;

    outcome_t outcome_q [$];
    step_t    plan [$];
    int       errors = 0;
    int       hot_gran = 0;

    shadow_memory_access_checker_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .address        (address),
        .byte_count     (byte_count),
        .shadow_value   (shadow_value),
        .done           (done),
        .violation      (violation),
        .ignored        (ignored),
        .fault_address  (fault_address),
        .fault_size     (fault_size),
        .fault_is_write (fault_is_write),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (errors < 40)
            $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Work out the result of one request and apply it to the shadow mirror
    function automatic outcome_t predict_outcome(input logic [1:0] md,
            input logic [ADDR_W-1:0] addr, input logic [COUNT_W-1:0] cnt,
            input logic [SHADOW_W-1:0] val);
        outcome_t                 o;
        logic [63:0]              base;
        logic [63:0]              off;
        logic [63:0]              end_byte;
        logic [GRANULE_SHIFT-1:0] end_sub;
        logic [GRANULE_SHIFT-1:0] hi;
        logic [SHADOW_W-1:0]      s;
        logic                     hit;
        int                       first;
        int                       last;
        int                       g;
        o = '0;
        base = {16'h0, win_base & ~GRAN_LOW};
        if (!chk_en || addr == '0 || {16'h0, addr} < base
                || {16'h0, addr} - base >= WINDOW_SPAN) begin
            o.ignored = 1'b1;
        end else if (cnt != '0) begin
            off = {16'h0, addr} - base;
            end_byte = off + cnt - 1;
            first = int'(off >> GRANULE_SHIFT);
            // clip at the window end: the last granule counts as full
            if ((end_byte >> GRANULE_SHIFT) >= SHADOW_ENTRIES) begin
                last = SHADOW_ENTRIES - 1;
                end_sub = '1;
            end else begin
                last = int'(end_byte >> GRANULE_SHIFT);
                end_sub = end_byte[GRANULE_SHIFT-1:0];
            end
            if (md == MODE_CHECK_READ || md == MODE_CHECK_WRITE) begin
                hit = 1'b0;
                g = first;
                while (!hit && g <= last) begin
                    s = shadow_ref[g];
                    hi = (g == last) ? end_sub : '1;
                    if (s != '0 && (s[SHADOW_W-1] || SHADOW_W'(hi) >= s))
                        hit = 1'b1;
                    g++;
                end
                if (hit) begin
                    o.violation = 1'b1;
                    o.fault_address = addr;
                    o.fault_size = cnt;
                    o.fault_is_write = (md == MODE_CHECK_WRITE);
                end
            end else begin
                for (g = first; g <= last; g++)
                    shadow_ref[g] = (md == MODE_POISON) ? val : '0;
            end
        end
        return o;
    endfunction

    // Mostly a hot spot of the window, some spread, window end and noise
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] base;
        int                r;
        base = win_base & ~GRAN_LOW;
        r = $urandom_range(99);
        if (r < 68)
            pick_address = base + ADDR_W'((hot_gran << GRANULE_SHIFT) + $urandom_range(0, 511));
        else if (r < 82)
            pick_address = base + ADDR_W'($urandom_range(0, WINDOW_SPAN - 1));
        else if (r < 90)
            pick_address = base + ADDR_W'(WINDOW_SPAN - $urandom_range(1, 64));
        else if (r < 93)
            pick_address = '0;
        else if (r < 95)
            pick_address = base - 1;
        else if (r < 97)
            pick_address = base + ADDR_W'(WINDOW_SPAN + $urandom_range(0, 7));
        else
            pick_address = ADDR_W'({$urandom(), $urandom()});
    endfunction

    task automatic add_step(input logic [1:0] md, input logic [ADDR_W-1:0] addr,
            input logic [COUNT_W-1:0] cnt, input logic [SHADOW_W-1:0] val,
            input bit typed, input outcome_t want);
        step_t st;
        st.md = md;
        st.addr = addr;
        st.cnt = cnt;
        st.val = val;
        st.typed = typed;
        st.want = want;
        plan.push_back(st);
    endtask

    // Write one register; the block must be idle
    task automatic program_reg(input logic idx, input logic [ADDR_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == CFG_CHECKER_ENABLE)
            chk_en = data[0];
        else
            win_base = data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Hold until every pending result has come back
    task automatic drain();
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Present a request and hold it until taken; start stays high afterwards
    task automatic issue_request(input logic [1:0] md, input logic [ADDR_W-1:0] addr,
            input logic [COUNT_W-1:0] cnt, input logic [SHADOW_W-1:0] val,
            output outcome_t pred);
        start <= 1'b1;
        mode <= md;
        address <= addr;
        byte_count <= cnt;
        shadow_value <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pred = predict_outcome(md, addr, cnt, val);
    endtask

    // Random requests until target is reached (counting only handled ones
    // unless count_every is set)
    task automatic run_phase(input int target, input bit count_every, input int idle_pct);
        outcome_t            o;
        logic [1:0]          md;
        logic [COUNT_W-1:0]  cnt;
        logic [SHADOW_W-1:0] val;
        int                  served;
        int                  r;
        served = 0;
        hot_gran = $urandom_range(1) ? 0 : $urandom_range(0, SHADOW_ENTRIES - 64);
        while (served < target) begin
            r = $urandom_range(99);
            if (r < 30)
                md = MODE_POISON;
            else if (r < 45)
                md = MODE_UNPOISON;
            else if (r < 75)
                md = MODE_CHECK_READ;
            else
                md = MODE_CHECK_WRITE;
            r = $urandom_range(99);
            if (r < 80)
                cnt = COUNT_W'($urandom_range(0, 24));
            else if (r < 95)
                cnt = COUNT_W'($urandom_range(0, 512));
            else
                cnt = COUNT_W'($urandom_range(0, 65535));
            r = $urandom_range(99);
            if (r < 40)
                val = SHADOW_W'($urandom_range(1, 7));
            else if (r < 70)
                val = SHADOW_W'($urandom_range(128, 255));
            else if (r < 85)
                val = SHADOW_W'($urandom_range(8, 127));
            else
                val = SHADOW_W'($urandom_range(0, 255));
            issue_request(md, pick_address(), cnt, val, o);
            outcome_q.push_back(o);
            if (count_every || !o.ignored)
                served++;
            // occasional full pause, else random gaps
            if ($urandom_range(99) < 2) begin
                start <= 1'b0;
                drain();
            end else if (int'($urandom_range(99)) < idle_pct) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        start <= 1'b0;
    endtask

    // Compare each strobed result with the oldest expectation
    always @(posedge clk) begin : result_monitor
        outcome_t want;
        if (rst_n && done) begin
            if (outcome_q.size() == 0) begin
                report_mismatch("result with no request pending");
            end else begin
                want = outcome_q.pop_front();
                if (violation !== want.violation)
                    report_mismatch($sformatf("violation got %b want %b",
                        violation, want.violation));
                if (ignored !== want.ignored)
                    report_mismatch($sformatf("ignored got %b want %b",
                        ignored, want.ignored));
                if (fault_address !== want.fault_address)
                    report_mismatch($sformatf("fault_address got %h want %h",
                        fault_address, want.fault_address));
                if (fault_size !== want.fault_size)
                    report_mismatch($sformatf("fault_size got %h want %h",
                        fault_size, want.fault_size));
                if (fault_is_write !== want.fault_is_write)
                    report_mismatch($sformatf("fault_is_write got %b want %b",
                        fault_is_write, want.fault_is_write));
            end
        end
    end

    initial begin : stimulus
        outcome_t pred;
        foreach (shadow_ref[k])
            shadow_ref[k] = '0;

        // Directed table, window at 0x1000 (low bits of the base dropped)
        add_step(MODE_CHECK_READ,  48'h1000, 16'd8, 8'h00, 1, '0);
        add_step(MODE_CHECK_READ,  48'h0, 16'd4, 8'h00, 1, {1'b0, 1'b1, 48'h0, 16'h0, 1'b0});
        add_step(MODE_CHECK_WRITE, 48'h0FFF, 16'd1, 8'h00, 1,
            {1'b0, 1'b1, 48'h0, 16'h0, 1'b0});
        add_step(MODE_CHECK_READ,  48'h9000, 16'd1, 8'h00, 1,
            {1'b0, 1'b1, 48'h0, 16'h0, 1'b0});
        add_step(MODE_POISON, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 8'hFF, 1,
            {1'b0, 1'b1, 48'h0, 16'h0, 1'b0});
        add_step(MODE_POISON,      48'h1000, 16'd0, 8'hFF, 1, '0);
        add_step(MODE_POISON,      48'h1000, 16'd16, 8'h80, 1, '0);
        add_step(MODE_CHECK_READ,  48'h1000, 16'd1, 8'h00, 1,
            {1'b1, 1'b0, 48'h1000, 16'd1, 1'b0});
        add_step(MODE_CHECK_WRITE, 48'h1008, 16'd8, 8'h00, 1,
            {1'b1, 1'b0, 48'h1008, 16'd8, 1'b1});
        add_step(MODE_CHECK_READ,  48'h1010, 16'd8, 8'h00, 1, '0);
        add_step(MODE_CHECK_READ,  48'h1000, 16'd0, 8'h00, 1, '0);
        add_step(MODE_UNPOISON,    48'h1000, 16'd16, 8'hAA, 1, '0);
        add_step(MODE_CHECK_WRITE, 48'h1000, 16'd16, 8'h00, 1, '0);
        // partial granule: only the first five bytes valid
        add_step(MODE_POISON,      48'h1020, 16'd1, 8'h05, 0, '0);
        add_step(MODE_CHECK_READ,  48'h1020, 16'd5, 8'h00, 0, '0);
        add_step(MODE_CHECK_WRITE, 48'h1024, 16'd2, 8'h00, 0, '0);
        add_step(MODE_CHECK_READ,  48'h101C, 16'd8, 8'h00, 0, '0);
        // ranges running past the window end
        add_step(MODE_POISON,      48'h8FF8, 16'hFFFF, 8'h7F, 0, '0);
        add_step(MODE_CHECK_READ,  48'h8FF0, 16'hFFFF, 8'h00, 0, '0);
        add_step(MODE_POISON,      48'h8FFF, 16'hFFFF, 8'h08, 0, '0);
        add_step(MODE_CHECK_WRITE, 48'h8FFF, 16'd1, 8'h00, 0, '0);
        add_step(MODE_POISON,      48'h1040, 16'd8, 8'hFF, 0, '0);
        add_step(MODE_CHECK_WRITE, 48'h1040, 16'hFFFF, 8'h00, 1,
            {1'b1, 1'b0, 48'h1040, 16'hFFFF, 1'b1});
        add_step(MODE_UNPOISON,    48'h1001, 16'hFFFF, 8'h00, 0, '0);
        add_step(MODE_CHECK_READ,  48'h1001, 16'hFFFF, 8'h00, 0, '0);

        // Reset, then hold through the clearing pass
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        while (busy)
            @(posedge clk);

        program_reg(CFG_CHECKER_ENABLE, 48'h1);
        program_reg(CFG_WINDOW_BASE, 48'h1003);
        for (int i = 0; i < plan.size(); i++) begin
            issue_request(plan[i].md, plan[i].addr, plan[i].cnt, plan[i].val, pred);
            outcome_q.push_back(plan[i].typed ? plan[i].want : pred);
        end
        start <= 1'b0;
        drain();

        // Random phases over several register settings
        program_reg(CFG_WINDOW_BASE, 48'h0);
        run_phase(330, 0, 0);
        drain();

        program_reg(CFG_CHECKER_ENABLE, {ADDR_W'({$urandom(), $urandom()}) | 48'h1});
        program_reg(CFG_WINDOW_BASE, ADDR_W'({$urandom(), $urandom()}));
        run_phase(330, 0, 50);
        drain();

        program_reg(CFG_CHECKER_ENABLE, ADDR_W'({$urandom(), $urandom()}) & ~48'h1);
        run_phase(60, 1, 38);
        drain();

        program_reg(CFG_CHECKER_ENABLE, 48'h1);
        program_reg(CFG_WINDOW_BASE, 48'hFFFF_FFFF_FFFF);
        run_phase(100, 1, 50);
        drain();

        program_reg(CFG_WINDOW_BASE, 48'hFFFF_FFFF_8000);
        run_phase(280, 0, 50);
        drain();

        program_reg(CFG_WINDOW_BASE, ADDR_W'({$urandom(), $urandom()}));
        run_phase(330, 0, 38);
        drain();

        program_reg(CFG_WINDOW_BASE, ADDR_W'({$urandom(), $urandom()}));
        run_phase(320, 0, 0);
        drain();

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #(64'd300_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/smac_pkg.sv
rtl/core/smac_granule_walker.sv
rtl/core/shadow_memory_access_checker_core.sv
rtl/core/smac_checker.sv
tb/tb.sv
